// File: src/radix_converter_base_2_to_36_assert.svh
// Assertion macros for the radix converter.
`ifndef RADIX_CONVERTER_BASE_2_TO_36_ASSERT_SVH
`define RADIX_CONVERTER_BASE_2_TO_36_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RCB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check without reset masking, used for conditions that also hold in reset.
`define RCB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/rcb_pkg.sv
// Package: types, codes, constants and digit conversion functions of the radix converter.
package rcb_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned MAX_DIGITS     = 64;
  localparam int unsigned BASE_W         = 6;
  localparam int unsigned DIGIT_W        = 6;
  localparam int unsigned CHAR_W         = 7;
  localparam logic [BASE_W-1:0] IN_BASE_RST  = 6'd2;
  localparam logic [BASE_W-1:0] OUT_BASE_RST = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BASE_ERR = 2'd1,
    ST_OVF      = 2'd2
  } status_e;

  typedef enum logic {
    CFG_IN_BASE  = 1'b0,
    CFG_OUT_BASE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic               kind;
    logic [7:0]         digit_char;
    logic signed [63:0] whole_value;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_out;
    status_e           status;
  } out_item_t;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < 6'd36) begin
      c = 7'h61 + CHAR_W'(d - 6'd10);
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

  function automatic logic [DIGIT_W-1:0] char_to_digit(input logic [7:0] c);
    logic [DIGIT_W-1:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = DIGIT_W'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = DIGIT_W'(c - 8'h61 + 8'd10);
    end else begin
      d = '0;
    end
    return d;
  endfunction

endpackage

// File: src/radix_converter_base_2_to_36.sv
// Top level: radix converter, bases 2 to 36, with configuration registers.
//
//   channel  direction  handshake          payload
//   input    in         push_i / full_o    in_i  (rcb_pkg::in_item_t)
//   result   out        pop_i / empty_o    out_o (rcb_pkg::out_item_t)
//   config   in         cfg_we_i           cfg_idx_i, cfg_data_i
//
// A digit character without last_in is accumulated in the front part.
// A conversion takes the job, then divides by out_base in the divider, 8 quotient
// bits per cycle, producing one digit per pass, then reads each digit from the
// buffer (S_RD, S_PUT).
// An error result is loaded from state S_ERR. A two-entry job queue lets the front keep
// accepting while the back converts; full_o rises when the queue is full.
// Reset clears accumulator, overflow flag and control state; no clearing pass.
module radix_converter_base_2_to_36 #(
  parameter int unsigned VALUE_BITS = rcb_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  rcb_pkg::in_item_t          in_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output rcb_pkg::out_item_t         out_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rcb_pkg::BASE_W-1:0] cfg_data_i
);

  logic [rcb_pkg::BASE_W-1:0] in_base_q, out_base_q;
  logic                       accept;
  logic                       job_push, job_valid, job_pop;
  logic [VALUE_BITS:0]        job_w, job_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_base_q  <= rcb_pkg::IN_BASE_RST;
      out_base_q <= rcb_pkg::OUT_BASE_RST;
    end else if (cfg_we_i) begin
      case (rcb_pkg::cfg_idx_e'(cfg_idx_i))
        rcb_pkg::CFG_IN_BASE:  in_base_q  <= cfg_data_i;
        rcb_pkg::CFG_OUT_BASE: out_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = push_i && !full_o;

  rcb_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_i),
    .in_base_i (in_base_q),
    .job_push_o(job_push),
    .job_o     (job_w)
  );

  rcb_fifo #(.WIDTH(VALUE_BITS + 1)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_w),
    .full_o (full_o),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .rdata_o(job_r)
  );

  rcb_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_r),
    .job_pop_o  (job_pop),
    .out_base_i (out_base_q),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_o      (out_o)
  );

endmodule

// File: src/rcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcb_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rcb_fifo.sv
// Two-entry job queue between the front and back parts.
module rcb_fifo #(
  parameter int unsigned WIDTH = 65
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: src/rcb_front.sv
// Front part: digit accumulation, magnitude of whole numbers, job dispatch.
module rcb_front #(
  parameter int unsigned VALUE_BITS = rcb_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  rcb_pkg::in_item_t             item_i,
  input  logic [rcb_pkg::BASE_W-1:0]    in_base_i,
  output logic                          job_push_o,
  output logic [VALUE_BITS:0]           job_o
);

  localparam int unsigned FULL_W = VALUE_BITS + rcb_pkg::BASE_W + 1;

  logic [VALUE_BITS-1:0]      acc_q, acc_d;
  logic                       ovf_q, ovf_d;
  logic [rcb_pkg::DIGIT_W-1:0] dig;
  logic [FULL_W-1:0]          full_sum;
  logic                       step_ovf;
  logic [63:0]                mag;
  logic                       mag_ovf;

  always_comb begin
    dig      = rcb_pkg::char_to_digit(item_i.digit_char);
    full_sum = FULL_W'(acc_q) * FULL_W'(in_base_i) + FULL_W'(dig);
    step_ovf = (full_sum >> VALUE_BITS) != '0;
    mag      = item_i.whole_value[63] ? (64'd0 - item_i.whole_value) : item_i.whole_value;
    mag_ovf  = (mag >> VALUE_BITS) != 64'd0;

    acc_d      = acc_q;
    ovf_d      = ovf_q;
    job_push_o = 1'b0;
    job_o      = {mag_ovf, mag[VALUE_BITS-1:0]};
    if (accept_i) begin
      if (item_i.kind) begin
        job_push_o = 1'b1;
      end else if (item_i.last_in) begin
        job_push_o = 1'b1;
        job_o      = {ovf_q | step_ovf, full_sum[VALUE_BITS-1:0]};
        acc_d      = '0;
        ovf_d      = 1'b0;
      end else begin
        acc_d = full_sum[VALUE_BITS-1:0];
        ovf_d = ovf_q | step_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

// File: src/rcb_back.sv
// Back part: digit-serial division by out_base, digit buffer, result register.
`include "radix_converter_base_2_to_36_assert.svh"

module rcb_back #(
  parameter int unsigned VALUE_BITS = rcb_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  logic [VALUE_BITS:0]        job_i,
  output logic                       job_pop_o,
  input  logic [rcb_pkg::BASE_W-1:0] out_base_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output rcb_pkg::out_item_t         out_o
);

  localparam int unsigned NCYC  = (VALUE_BITS + 7) / 8;
  localparam int unsigned W     = NCYC * 8;
  localparam int unsigned CNT_W = (NCYC > 1) ? $clog2(NCYC) : 1;
  localparam int unsigned AW    = $clog2(rcb_pkg::MAX_DIGITS);
  localparam int unsigned NW    = AW + 1;

  typedef enum logic [2:0] {S_IDLE, S_ERR, S_DIV, S_RD, S_PUT} state_e;

  state_e                      state_q;
  logic [W-1:0]                val_q;
  logic [rcb_pkg::DIGIT_W-1:0] rem_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [NW-1:0]               n_q;
  logic [AW-1:0]               idx_q;
  rcb_pkg::status_e            err_q;
  logic                        oval_q;
  rcb_pkg::out_item_t          out_q;

  logic [W-1:0]                val_d;
  logic [6:0]                  r;
  logic [7:0]                  qbits;
  logic                        slot_free;
  logic                        out_load;
  logic                        base_bad;
  logic                        ram_we;
  logic [rcb_pkg::DIGIT_W-1:0] ram_rdata;

  assign slot_free = !oval_q || pop_i;
  assign out_load  = slot_free && ((state_q == S_ERR) || (state_q == S_PUT));
  assign base_bad  = (out_base_i < rcb_pkg::BASE_MIN) || (out_base_i > rcb_pkg::BASE_MAX);
  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;
  assign ram_we    = (state_q == S_DIV) && (cnt_q == CNT_W'(NCYC - 1));
  assign empty_o   = !oval_q;
  assign out_o     = out_q;

  always_comb begin
    r     = {1'b0, rem_q};
    qbits = '0;
    for (int i = 0; i < 8; i++) begin
      r = {r[5:0], val_q[W-1-i]};
      if (r >= {1'b0, out_base_i}) begin
        r            = r - {1'b0, out_base_i};
        qbits[7-i]   = 1'b1;
      end
    end
    val_d = (val_q << 8) | W'(qbits);
  end

  rcb_ram #(
    .WIDTH(rcb_pkg::DIGIT_W),
    .DEPTH(rcb_pkg::MAX_DIGITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(n_q[AW-1:0]),
    .wdata_i(r[rcb_pkg::DIGIT_W-1:0]),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
      cnt_q   <= '0;
      n_q     <= '0;
      idx_q   <= '0;
      rem_q   <= '0;
      val_q   <= '0;
      err_q   <= rcb_pkg::ST_OK;
      out_q   <= '0;
    end else begin
      if (out_load) begin
        oval_q <= 1'b1;
      end else if (pop_i && oval_q) begin
        oval_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            val_q <= W'(job_i[VALUE_BITS-1:0]);
            rem_q <= '0;
            cnt_q <= '0;
            n_q   <= '0;
            if (base_bad) begin
              err_q   <= rcb_pkg::ST_BASE_ERR;
              state_q <= S_ERR;
            end else if (job_i[VALUE_BITS]) begin
              err_q   <= rcb_pkg::ST_OVF;
              state_q <= S_ERR;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            out_q   <= '{out_char: rcb_pkg::CHAR_ZERO, last_out: 1'b1, status: err_q};
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          val_q <= val_d;
          if (cnt_q == CNT_W'(NCYC - 1)) begin
            cnt_q <= '0;
            rem_q <= '0;
            n_q   <= n_q + 1'b1;
            if (val_d == '0 || n_q == NW'(rcb_pkg::MAX_DIGITS - 1)) begin
              idx_q   <= n_q[AW-1:0];
              state_q <= S_RD;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
            rem_q <= r[rcb_pkg::DIGIT_W-1:0];
          end
        end
        S_RD: begin
          state_q <= S_PUT;
        end
        S_PUT: begin
          if (slot_free) begin
            out_q  <= '{out_char: rcb_pkg::digit_to_char(ram_rdata),
                        last_out: (idx_q == '0), status: rcb_pkg::ST_OK};
            if (idx_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `RCB_ASSERT(a_err_is_last, clk_i, rst_ni,
              (oval_q && out_q.status != rcb_pkg::ST_OK) |-> out_q.last_out,
              "error result without last flag")
  `RCB_ASSERT(a_digit_lt_base, clk_i, rst_ni,
              ram_we |-> (r < {1'b0, out_base_i}), "stored digit not below base")
  `RCB_ASSERT(a_count_bound, clk_i, rst_ni,
              n_q <= NW'(rcb_pkg::MAX_DIGITS), "digit count beyond buffer")
  `RCB_ASSERT(a_pop_only_idle, clk_i, rst_ni,
              job_pop_o |=> (state_q != S_IDLE), "job taken but sequencer stayed idle")

endmodule

// File: verif/radix_converter_base_2_to_36_tb.sv
// Testbench for the radix converter: directed table plus random numbers, checked by a predictor.
module radix_converter_base_2_to_36_tb;
  import rcb_pkg::*;

  localparam int unsigned WDOG_LIMIT = 6000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned ITEMS_PER_PHASE = 40;

  typedef struct {
    bit [5:0]  ib;
    bit [5:0]  ob;
    bit        kind;
    bit [7:0]  ch;
    bit [63:0] whole;
    bit        last;
    int        rep;
    bit        typed;
    bit [6:0]  ech;
    status_e   est;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push_i = 1'b0;
  logic       full_o;
  in_item_t   in_i = '0;
  logic       empty_o;
  logic       pop_i = 1'b0;
  out_item_t  out_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [5:0] cfg_data_i = '0;

  out_item_t  digits_expected[$];
  bit [5:0]   in_radix = IN_BASE_RST;
  bit [5:0]   out_radix = OUT_BASE_RST;
  bit [63:0]  acc_value = '0;
  bit         acc_ovf = 1'b0;
  bit         failed = 1'b0;
  int         send_idle = 0;
  int         recv_stall = 0;
  bit         hold_req = 1'b0;
  int         quiet_cycles = 0;

  radix_converter_base_2_to_36 dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic bit [5:0] char_value(bit [7:0] c);
    if (c >= "0" && c <= "9") return 6'(c - "0");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 10);
    return '0;
  endfunction

  function automatic bit [6:0] value_char(bit [5:0] d);
    return (d < 10) ? 7'(8'd48 + d) : 7'(8'd87 + d);
  endfunction

  function automatic void push_single(bit [6:0] c, status_e st);
    out_item_t r;
    r.out_char = c;
    r.last_out = 1'b1;
    r.status = st;
    digits_expected.push_back(r);
  endfunction

  function automatic void predict_digits(bit [63:0] v, bit ovf);
    bit [5:0] dig[64];
    int n;
    out_item_t r;
    n = 0;
    if (out_radix < 2 || out_radix > 36) begin
      push_single(CHAR_ZERO, ST_BASE_ERR);
      return;
    end
    if (ovf) begin
      push_single(CHAR_ZERO, ST_OVF);
      return;
    end
    do begin
      dig[n] = 6'(v % out_radix);
      v = v / out_radix;
      n++;
    end while (v != 0 && n < 64);
    for (int k = 0; k < n; k++) begin
      r.out_char = value_char(dig[n - 1 - k]);
      r.last_out = (k == n - 1);
      r.status = ST_OK;
      digits_expected.push_back(r);
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    bit [63:0] d;
    if (it.kind) begin
      predict_digits(it.whole_value[63] ? -it.whole_value : it.whole_value, 1'b0);
      return;
    end
    d = char_value(it.digit_char);
    if (in_radix != 0 && acc_value > (64'hFFFF_FFFF_FFFF_FFFF - d) / in_radix) acc_ovf = 1'b1;
    acc_value = acc_value * in_radix + d;
    if (it.last_in) begin
      predict_digits(acc_value, acc_ovf);
      acc_value = '0;
      acc_ovf = 1'b0;
    end
  endfunction

  task automatic send(in_item_t it, bit typed = 0, bit [6:0] ech = '0, status_e est = ST_OK);
    push_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (full_o);
    predict_item(it);
    if (typed && (it.kind || it.last_in)) begin
      digits_expected.pop_back();
      push_single(ech, est);
    end
    while ($urandom_range(99) < send_idle) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    push_i <= 1'b0;
    while (digits_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [5:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IN_BASE) in_radix = val;
    else out_radix = val;
  endtask

  task automatic set_bases(bit [5:0] ib, bit [5:0] ob, bit force_wr);
    if (!force_wr && ib == in_radix && ob == out_radix) return;
    drain();
    write_reg(CFG_IN_BASE, ib);
    write_reg(CFG_OUT_BASE, ob);
  endtask

  function automatic in_item_t rand_char(bit last);
    in_item_t it;
    int d;
    it.kind = 1'b0;
    it.whole_value = {$urandom, $urandom};
    it.last_in = last;
    if ($urandom_range(99) < 85) begin
      d = (in_radix >= 2 && in_radix <= 36) ? $urandom_range(in_radix - 1) : $urandom_range(35);
      it.digit_char = {1'b0, value_char(6'(d))};
    end else begin
      it.digit_char = 8'($urandom);
    end
    return it;
  endfunction

  function automatic in_item_t rand_whole();
    in_item_t it;
    it.kind = 1'b1;
    it.digit_char = 8'($urandom);
    it.last_in = $urandom_range(1);
    case ($urandom_range(3))
      0: it.whole_value = {$urandom, $urandom};
      1: it.whole_value = $signed(64'($urandom_range(1000))) * ($urandom_range(1) ? -1 : 1);
      2: it.whole_value = $urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      default: it.whole_value = 64'($urandom) >> $urandom_range(31);
    endcase
    return it;
  endfunction

  // result side: checks, random stalls and the long hold-off
  initial begin
    int hold_cnt;
    out_item_t e;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        if (digits_expected.size() == 0) begin
          $error("unexpected transaction: out_char %0h", out_o.out_char);
          failed = 1'b1;
        end else begin
          e = digits_expected.pop_front();
          if (out_o.out_char !== e.out_char) begin
            $error("out_char: expected %0h actual %0h", e.out_char, out_o.out_char);
            failed = 1'b1;
          end
          if (out_o.last_out !== e.last_out) begin
            $error("last_out: expected %0b actual %0b", e.last_out, out_o.last_out);
            failed = 1'b1;
          end
          if (out_o.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_o.status);
            failed = 1'b1;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab[] = '{
      '{6'd2, 6'd16, 1, 8'h00, 64'h0, 0, 1, 1, 7'h30, ST_OK},
      '{6'd2, 6'd16, 1, 8'hff, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1, 0, 7'h0, ST_OK},
      '{6'd2, 6'd2, 1, 8'h00, 64'h8000_0000_0000_0000, 0, 1, 0, 7'h0, ST_OK},
      '{6'd2, 6'd36, 1, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 1, 7'h31, ST_OK},
      '{6'd2, 6'd0, 1, 8'h00, 64'd5, 0, 1, 1, 7'h30, ST_BASE_ERR},
      '{6'd2, 6'd63, 1, 8'h00, 64'd5, 0, 1, 1, 7'h30, ST_BASE_ERR},
      '{6'd36, 6'd10, 0, "z", 64'h0, 0, 1, 0, 7'h0, ST_OK},
      '{6'd36, 6'd10, 0, "Z", 64'h0, 0, 1, 0, 7'h0, ST_OK},
      '{6'd36, 6'd10, 0, 8'hff, 64'h0, 0, 1, 0, 7'h0, ST_OK},
      '{6'd36, 6'd10, 0, "!", 64'h0, 1, 1, 0, 7'h0, ST_OK},
      '{6'd2, 6'd10, 0, "9", 64'h0, 1, 1, 0, 7'h0, ST_OK},
      '{6'd0, 6'd10, 0, "7", 64'h0, 1, 2, 0, 7'h0, ST_OK},
      '{6'd1, 6'd10, 0, "7", 64'h0, 1, 3, 0, 7'h0, ST_OK},
      '{6'd63, 6'd36, 0, "z", 64'h0, 1, 11, 1, 7'h30, ST_OVF},
      '{6'd63, 6'd37, 0, "z", 64'h0, 1, 11, 1, 7'h30, ST_BASE_ERR}
    };
    int idle_tab[4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{31, 31}};
    in_item_t it;
    int cnt;
    int len;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      set_bases(dir_tab[i].ib, dir_tab[i].ob, i == 0);
      for (int r = 0; r < dir_tab[i].rep; r++) begin
        it.kind = dir_tab[i].kind;
        it.digit_char = dir_tab[i].ch;
        it.whole_value = dir_tab[i].whole;
        it.last_in = (r == dir_tab[i].rep - 1) ? dir_tab[i].last : 1'b0;
        send(it, dir_tab[i].typed, dir_tab[i].ech, dir_tab[i].est);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_bases(6'd36, 6'd2, 1);
        1: set_bases(6'($urandom_range(2, 36)), 6'($urandom_range(2, 36)), 1);
        2: set_bases(6'd2, 6'd36, 1);
        default: set_bases(6'($urandom_range(63)), 6'($urandom_range(63)), 1);
      endcase
      send_idle = idle_tab[ph][0];
      recv_stall = idle_tab[ph][1];
      if (ph == 0) hold_req = 1'b1;
      cnt = 0;
      while (cnt < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 30) begin
          send(rand_whole());
          cnt++;
        end else begin
          len = $urandom_range(1, 16);
          for (int k = 0; k < len; k++) begin
            send(rand_char(k == len - 1 && $urandom_range(19) != 0));
            cnt++;
          end
        end
      end
      drain();
    end

    recv_stall = 0;
    drain();
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
